[design/button_gesture_and_battery_monitor_assert.svh]
// ----------------------------------------------------------------------------
// button gesture and battery monitor assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_AND_BATTERY_MONITOR_ASSERT_SVH
`define BUTTON_GESTURE_AND_BATTERY_MONITOR_ASSERT_SVH

// same-cycle implication
`define BGBM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bgbm assertion failed");

// next-cycle implication
`define BGBM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bgbm assertion failed");

`endif

[design/bgbm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbm_pkg
// types and constants shared by the button gesture and battery monitor
// ----------------------------------------------------------------------------
package bgbm_pkg;

   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LONG_PRESS_MS        = 3'd0,
      CSR_POWER_OFF_HOLDOFF_MS = 3'd1,
      CSR_CLICK_MAX_MS         = 3'd2,
      CSR_CLICK_MIN_MS         = 3'd3,
      CSR_CLICK_GAP_MS         = 3'd4,
      CSR_CLICK_TIMEOUT_MS     = 3'd5,
      CSR_BATTERY_PERIOD_TICKS = 3'd6,
      CSR_BATTERY_EMPTY_MV     = 3'd7
   } csr_index_type;

   localparam logic [15:0] LongPressReset   = 16'd2000;
   localparam logic [15:0] HoldoffReset     = 16'd10000;
   localparam logic [15:0] ClickMaxReset    = 16'd500;
   localparam logic [15:0] ClickMinReset    = 16'd20;
   localparam logic [15:0] ClickGapReset    = 16'd500;
   localparam logic [15:0] ClickTimeoutReset = 16'd400;
   localparam logic [15:0] BattPeriodReset  = 16'd100;
   localparam logic [13:0] BattEmptyReset   = 14'd3200;
   localparam logic [6:0]  BattLevelReset   = 7'd100;
   localparam logic [6:0]  BattLevelFull    = 7'd100;
   // mV above empty at which the level saturates (10 mV per percent)
   localparam logic [13:0] BattFullSpanMv   = 14'd1000;

   typedef struct packed {
      logic [15:0] long_press_ms;
      logic [15:0] power_off_holdoff_ms;
      logic [15:0] click_max_ms;
      logic [15:0] click_min_ms;
      logic [15:0] click_gap_ms;
      logic [15:0] click_timeout_ms;
      logic [15:0] battery_period_ticks;
      logic [13:0] battery_empty_mv;
   } cfg_type;

   typedef struct packed {
      logic        button_level;
      logic [31:0] now_ms;
      logic [11:0] sense_mv;
      logic        sense_valid;
   } req_type;

   typedef struct packed {
      logic       power_off;
      logic       triple_click;
      logic       double_click_restart;
      logic [6:0] battery_percent;
      logic [1:0] clicks_pending;
   } rsp_type;

   typedef struct packed {
      logic       power_off;
      logic       triple_click;
      logic       double_click_restart;
      logic [1:0] clicks_pending;
   } gesture_type;

endpackage

[design/bgbm_gesture.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbm_gesture
// press tracking, long-press power-off and click run detection
// ----------------------------------------------------------------------------
module bgbm_gesture (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  button_level,
   input  logic [31:0]           now_ms,
   input  bgbm_pkg::cfg_type     cfg,
   output bgbm_pkg::gesture_type gesture
);

   logic [31:0] press_start_ff, press_start_in;
   logic [31:0] last_release_ff, last_release_in;
   logic [1:0]  click_count_ff, click_count_in;

   logic [31:0] held_ms;
   logic [31:0] since_release_ms;
   logic [31:0] idle_ms;
   logic        released_now;
   logic        is_click;
   logic        p_off;
   logic        triple;
   logic        restart;
   logic [1:0]  count_tmp;

   assign held_ms = now_ms - press_start_ff;
   assign since_release_ms = now_ms - last_release_ff;
   assign is_click = (held_ms < {16'd0, cfg.click_max_ms}) &&
                     (held_ms > {16'd0, cfg.click_min_ms});

   always_comb begin
      press_start_in  = press_start_ff;
      last_release_in = last_release_ff;
      count_tmp       = click_count_ff;
      released_now    = 1'b0;
      p_off           = 1'b0;
      triple          = 1'b0;
      if (button_level) begin
         if (press_start_ff == 32'd0) begin
            press_start_in = now_ms;
         end else if (held_ms > {16'd0, cfg.long_press_ms}) begin
            p_off          = 1'b1;
            press_start_in = now_ms + {16'd0, cfg.power_off_holdoff_ms};
         end
      end else begin
         press_start_in = 32'd0;
         // a start still in the future (after holdoff) counts nothing
         if (press_start_ff != 32'd0 && press_start_ff <= now_ms && is_click) begin
            released_now    = 1'b1;
            last_release_in = now_ms;
            if (click_count_ff == 2'd0 ||
                since_release_ms < {16'd0, cfg.click_gap_ms}) begin
               count_tmp = click_count_ff + 2'd1;
               if (count_tmp == 2'd3) begin
                  triple    = 1'b1;
                  count_tmp = 2'd0;
               end
            end else begin
               count_tmp = 2'd1;
            end
         end
      end
   end

   // time since the last release after this tick's update
   assign idle_ms = released_now ? 32'd0 : since_release_ms;

   always_comb begin
      click_count_in = count_tmp;
      restart        = 1'b0;
      if (count_tmp != 2'd0 && idle_ms >= {16'd0, cfg.click_timeout_ms}) begin
         restart        = (count_tmp == 2'd2);
         click_count_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_start_ff  <= 32'd0;
         last_release_ff <= 32'd0;
         click_count_ff  <= 2'd0;
      end else if (step) begin
         press_start_ff  <= press_start_in;
         last_release_ff <= last_release_in;
         click_count_ff  <= click_count_in;
      end
   end

   assign gesture.power_off            = p_off;
   assign gesture.triple_click         = triple;
   assign gesture.double_click_restart = restart;
   assign gesture.clicks_pending       = click_count_in;

endmodule

[design/bgbm_battery.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbm_battery
// periodic battery sample evaluation and percent conversion
// ----------------------------------------------------------------------------
module bgbm_battery (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [11:0]       sense_mv,
   input  logic              sense_valid,
   input  bgbm_pkg::cfg_type cfg,
   output logic [6:0]        battery_percent
);

   logic [15:0] tick_count_ff, tick_count_in;
   logic [6:0]  level_ff, level_in;
   logic [15:0] tick_next;
   logic [12:0] batt_mv;
   logic [13:0] above_empty;
   logic [17:0] scaled;
   logic [6:0]  pct;

   assign tick_next   = tick_count_ff + 16'd1;
   assign batt_mv     = {sense_mv, 1'b0};
   assign above_empty = {1'b0, batt_mv} - cfg.battery_empty_mv;
   // divide by 10 as multiply by 205 and shift by 11, exact below 1029
   assign scaled      = above_empty[9:0] * 8'd205;

   always_comb begin
      if ({1'b0, batt_mv} < cfg.battery_empty_mv) begin
         pct = 7'd0;
      end else if (above_empty >= bgbm_pkg::BattFullSpanMv) begin
         pct = bgbm_pkg::BattLevelFull;
      end else begin
         pct = scaled[17:11];
      end
   end

   always_comb begin
      tick_count_in = tick_next;
      level_in      = level_ff;
      if (tick_next >= cfg.battery_period_ticks) begin
         tick_count_in = 16'd0;
         if (sense_valid && sense_mv != 12'd0) begin
            level_in = pct;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= 16'd0;
         level_ff      <= bgbm_pkg::BattLevelReset;
      end else if (step) begin
         tick_count_ff <= tick_count_in;
         level_ff      <= level_in;
      end
   end

   assign battery_percent = level_in;

endmodule

[design/button_gesture_and_battery_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_and_battery_monitor
// button multi-click and long-press detector with battery level tracking
// ----------------------------------------------------------------------------
// One request is one periodic tick (button level, millisecond time, battery
// sample) and yields exactly one response with the gesture pulses, the click
// count and the battery percent after that tick. A request is registered,
// evaluated by compare-and-update logic and the result is held in an output
// register, so the block accepts one request per clock while the response
// is not stalled, and a response is valid once its request has passed both
// registers; a stalled response holds the pipe, with the input register
// still taking one more request. The user must write settings through the
// csr port only while no request is in flight; the block does not enforce
// it. Settings reset to the documented defaults.
module button_gesture_and_battery_monitor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bgbm_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bgbm_pkg::rsp_type    rsp_data,
   input  logic                 csr_write,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata
);

   bgbm_pkg::cfg_type     cfg_ff;
   bgbm_pkg::req_type     req_ff;
   bgbm_pkg::rsp_type     rsp_ff, rsp_in;
   bgbm_pkg::gesture_type gesture;
   logic                  req_valid_ff;
   logic                  rsp_valid_ff;
   logic                  advance;
   logic [6:0]            battery_percent;

   // move the registered request into the response register
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms        <= bgbm_pkg::LongPressReset;
         cfg_ff.power_off_holdoff_ms <= bgbm_pkg::HoldoffReset;
         cfg_ff.click_max_ms         <= bgbm_pkg::ClickMaxReset;
         cfg_ff.click_min_ms         <= bgbm_pkg::ClickMinReset;
         cfg_ff.click_gap_ms         <= bgbm_pkg::ClickGapReset;
         cfg_ff.click_timeout_ms     <= bgbm_pkg::ClickTimeoutReset;
         cfg_ff.battery_period_ticks <= bgbm_pkg::BattPeriodReset;
         cfg_ff.battery_empty_mv     <= bgbm_pkg::BattEmptyReset;
      end else if (csr_write) begin
         case (bgbm_pkg::csr_index_type'(csr_index))
            bgbm_pkg::CSR_LONG_PRESS_MS:        cfg_ff.long_press_ms <= csr_wdata;
            bgbm_pkg::CSR_POWER_OFF_HOLDOFF_MS: cfg_ff.power_off_holdoff_ms <= csr_wdata;
            bgbm_pkg::CSR_CLICK_MAX_MS:         cfg_ff.click_max_ms <= csr_wdata;
            bgbm_pkg::CSR_CLICK_MIN_MS:         cfg_ff.click_min_ms <= csr_wdata;
            bgbm_pkg::CSR_CLICK_GAP_MS:         cfg_ff.click_gap_ms <= csr_wdata;
            bgbm_pkg::CSR_CLICK_TIMEOUT_MS:     cfg_ff.click_timeout_ms <= csr_wdata;
            bgbm_pkg::CSR_BATTERY_PERIOD_TICKS: cfg_ff.battery_period_ticks <= csr_wdata;
            bgbm_pkg::CSR_BATTERY_EMPTY_MV:     cfg_ff.battery_empty_mv <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
   end

   bgbm_gesture u_gesture (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .button_level (req_ff.button_level),
      .now_ms       (req_ff.now_ms),
      .cfg          (cfg_ff),
      .gesture      (gesture)
   );

   bgbm_battery u_battery (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .sense_mv        (req_ff.sense_mv),
      .sense_valid     (req_ff.sense_valid),
      .cfg             (cfg_ff),
      .battery_percent (battery_percent)
   );

   always_comb begin
      rsp_in.power_off            = gesture.power_off;
      rsp_in.triple_click         = gesture.triple_click;
      rsp_in.double_click_restart = gesture.double_click_restart;
      rsp_in.battery_percent      = battery_percent;
      rsp_in.clicks_pending       = gesture.clicks_pending;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/bgbm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbm_checker
// port-level checks for the button gesture and battery monitor
// ----------------------------------------------------------------------------
`include "button_gesture_and_battery_monitor_assert.svh"

module bgbm_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bgbm_pkg::rsp_type rsp_data
);

   // a finished run always leaves no clicks pending
   `BGBM_ASSERT_IMPLY(a_run_end_clears, clock, reset,
      rsp_valid && (rsp_data.triple_click || rsp_data.double_click_restart),
      rsp_data.clicks_pending == 2'd0)

   // power-off needs the button held, a completed click needs it released
   `BGBM_ASSERT_IMPLY(a_pulse_exclusive, clock, reset,
      rsp_valid && rsp_data.power_off, !rsp_data.triple_click)

   `BGBM_ASSERT_IMPLY(a_percent_range, clock, reset,
      rsp_valid, rsp_data.battery_percent <= 7'd100)

   `BGBM_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule

bind button_gesture_and_battery_monitor bgbm_checker u_bgbm_checker (.*);

[tb/bgbm_tick_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgbm_tick_result_check
// watches the tick, response and csr ports of the gesture and battery
// monitor, predicts every response from its own copy of the button, click
// and battery state, and compares the responses in order, field by field
// ----------------------------------------------------------------------------
module bgbm_tick_result_check
   import bgbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          outstanding
);

   cfg_type     settings;
   logic [31:0] press_start_ms;
   logic [31:0] last_release_ms;
   logic [1:0]  click_count;
   logic [15:0] tick_count;
   logic [6:0]  battery_level;

   rsp_type tick_results_due[$];

   function automatic rsp_type predict_tick_result(input req_type t);
      rsp_type     o;
      logic [31:0] held_ms;
      logic [13:0] batt_mv;
      logic [13:0] span_mv;
      logic [9:0]  pct;
      o = '0;
      if (t.button_level) begin
         if (press_start_ms == 32'd0) begin
            press_start_ms = t.now_ms;
         end else if (t.now_ms - press_start_ms > {16'd0, settings.long_press_ms}) begin
            o.power_off = 1'b1;
            press_start_ms = t.now_ms + {16'd0, settings.power_off_holdoff_ms};
         end
      end else begin
         if (press_start_ms != 32'd0 && press_start_ms <= t.now_ms) begin
            held_ms = t.now_ms - press_start_ms;
            press_start_ms = 32'd0;
            if (held_ms < {16'd0, settings.click_max_ms} &&
                held_ms > {16'd0, settings.click_min_ms}) begin
               if (click_count == 2'd0 ||
                   t.now_ms - last_release_ms < {16'd0, settings.click_gap_ms}) begin
                  click_count = click_count + 2'd1;
                  last_release_ms = t.now_ms;
                  if (click_count == 2'd3) begin
                     o.triple_click = 1'b1;
                     click_count = 2'd0;
                  end
               end else begin
                  // too late to continue the run, this click starts a new one
                  click_count = 2'd1;
                  last_release_ms = t.now_ms;
               end
            end
         end else begin
            press_start_ms = 32'd0;
         end
      end

      if (click_count != 2'd0 &&
          t.now_ms - last_release_ms >= {16'd0, settings.click_timeout_ms}) begin
         if (click_count == 2'd2) begin
            o.double_click_restart = 1'b1;
         end
         click_count = 2'd0;
      end

      tick_count = tick_count + 16'd1;
      if (tick_count >= settings.battery_period_ticks) begin
         tick_count = 16'd0;
         if (t.sense_valid && t.sense_mv != 12'd0) begin
            batt_mv = {1'b0, t.sense_mv, 1'b0};
            if (batt_mv < settings.battery_empty_mv) begin
               battery_level = 7'd0;
            end else begin
               span_mv = batt_mv - settings.battery_empty_mv;
               pct = 10'(span_mv / 14'd10);
               battery_level = (pct > 10'd100) ? BattLevelFull : pct[6:0];
            end
         end
      end

      o.battery_percent = battery_level;
      o.clicks_pending = click_count;
      return o;
   endfunction

   function automatic int field_mismatch(input string name, input logic [6:0] want,
                                         input logic [6:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      int      bad;
      if (reset) begin
         settings = '{LongPressReset, HoldoffReset, ClickMaxReset, ClickMinReset,
                      ClickGapReset, ClickTimeoutReset, BattPeriodReset, BattEmptyReset};
         press_start_ms = 32'd0;
         last_release_ms = 32'd0;
         click_count = 2'd0;
         tick_count = 16'd0;
         battery_level = BattLevelReset;
         tick_results_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_LONG_PRESS_MS:        settings.long_press_ms = csr_wdata;
               CSR_POWER_OFF_HOLDOFF_MS: settings.power_off_holdoff_ms = csr_wdata;
               CSR_CLICK_MAX_MS:         settings.click_max_ms = csr_wdata;
               CSR_CLICK_MIN_MS:         settings.click_min_ms = csr_wdata;
               CSR_CLICK_GAP_MS:         settings.click_gap_ms = csr_wdata;
               CSR_CLICK_TIMEOUT_MS:     settings.click_timeout_ms = csr_wdata;
               CSR_BATTERY_PERIOD_TICKS: settings.battery_period_ticks = csr_wdata;
               CSR_BATTERY_EMPTY_MV:     settings.battery_empty_mv = csr_wdata[13:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            tick_results_due.push_back(predict_tick_result(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (tick_results_due.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               want = tick_results_due.pop_front();
               bad = 0;
               bad += field_mismatch("power_off", 7'(want.power_off),
                                     7'(rsp_data.power_off));
               bad += field_mismatch("triple_click", 7'(want.triple_click),
                                     7'(rsp_data.triple_click));
               bad += field_mismatch("double_click_restart",
                                     7'(want.double_click_restart),
                                     7'(rsp_data.double_click_restart));
               bad += field_mismatch("battery_percent", want.battery_percent,
                                     rsp_data.battery_percent);
               bad += field_mismatch("clicks_pending", 7'(want.clicks_pending),
                                     7'(rsp_data.clicks_pending));
               mismatch_count += bad;
            end
         end
      end
      outstanding = tick_results_due.size();
   end

endmodule

[tb/button_gesture_and_battery_monitor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_and_battery_monitor_tb
// drives button ticks shaped as clicks, click runs, long presses and noise
// under several csr settings, with random gaps on both handshakes; the
// response check runs in a separate monitor module
// ----------------------------------------------------------------------------
module button_gesture_and_battery_monitor_tb;
   import bgbm_pkg::*;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   int          mismatch_count;
   int          outstanding;

   bit          no_idle = 1'b0;
   int unsigned sent = 0;
   logic [31:0] wall_ms = '0;
   cfg_type     settings;

   button_gesture_and_battery_monitor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bgbm_tick_result_check tick_result_monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // valid stays high across back-to-back requests
   task automatic send_tick(input logic lvl, input logic [31:0] at_ms,
                            input logic [11:0] mv, input logic ok);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 39) == 0) begin
         no_idle = !no_idle;
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{button_level: lvl, now_ms: at_ms, sense_mv: mv, sense_valid: ok};
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_sampled_tick(input logic lvl, input logic [31:0] at_ms);
      logic [11:0] mv;
      case ($urandom_range(0, 7))
         0: mv = 12'd0;
         1: mv = 12'hfff;
         2: mv = settings.battery_empty_mv[12:1] + 12'($urandom_range(0, 520));
         default: mv = 12'($urandom_range(0, 4095));
      endcase
      send_tick(lvl, at_ms, mv, $urandom_range(0, 3) != 0);
   endtask

   // press for hold_ms spread over n pressed ticks, release, then idle ticks
   task automatic press_gesture(input int unsigned hold_ms, input int unsigned rest_ms,
                                input int unsigned n);
      int unsigned m;
      int unsigned i;
      logic [31:0] t0;
      t0 = wall_ms + 32'd1 + 32'($urandom_range(0, 20));
      for (i = 0; i < n; i++) begin
         send_sampled_tick(1'b1, t0 + 32'(hold_ms * i / n));
      end
      send_sampled_tick(1'b0, t0 + hold_ms);
      m = $urandom_range(0, 2);
      for (i = 1; i <= m; i++) begin
         send_sampled_tick(1'b0, t0 + hold_ms + 32'(rest_ms * i / m));
      end
      wall_ms = t0 + hold_ms + rest_ms;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type s);
      csr_write <= 1'b1;
      csr_index <= CSR_LONG_PRESS_MS;        csr_wdata <= s.long_press_ms;
      @(posedge clock);
      csr_index <= CSR_POWER_OFF_HOLDOFF_MS; csr_wdata <= s.power_off_holdoff_ms;
      @(posedge clock);
      csr_index <= CSR_CLICK_MAX_MS;         csr_wdata <= s.click_max_ms;
      @(posedge clock);
      csr_index <= CSR_CLICK_MIN_MS;         csr_wdata <= s.click_min_ms;
      @(posedge clock);
      csr_index <= CSR_CLICK_GAP_MS;         csr_wdata <= s.click_gap_ms;
      @(posedge clock);
      csr_index <= CSR_CLICK_TIMEOUT_MS;     csr_wdata <= s.click_timeout_ms;
      @(posedge clock);
      csr_index <= CSR_BATTERY_PERIOD_TICKS; csr_wdata <= s.battery_period_ticks;
      @(posedge clock);
      csr_index <= CSR_BATTERY_EMPTY_MV;     csr_wdata <= {2'b00, s.battery_empty_mv};
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      settings = s;
   endtask

   initial begin : response_side
      int unsigned stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      cfg_type     defaults;
      cfg_type     s;
      int unsigned p;
      int unsigned goal;
      int unsigned hold_ms;
      int unsigned rest_ms;
      int unsigned n;
      int unsigned lo;
      int unsigned hi;
      // field order: long, holdoff, click max, click min, gap, timeout, period, empty
      defaults = '{LongPressReset, HoldoffReset, ClickMaxReset, ClickMinReset,
                   ClickGapReset, ClickTimeoutReset, BattPeriodReset, BattEmptyReset};
      settings = defaults;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed gestures under reset settings
      send_sampled_tick(1'b1, 32'd0);        // press at time zero reads as not pressed
      send_sampled_tick(1'b1, 32'd50);
      send_sampled_tick(1'b0, 32'd150);
      send_sampled_tick(1'b1, 32'd200);
      send_sampled_tick(1'b0, 32'd300);
      send_sampled_tick(1'b0, 32'd700);      // two clicks then timeout
      send_sampled_tick(1'b1, 32'd1000);
      send_sampled_tick(1'b0, 32'd1100);
      send_sampled_tick(1'b1, 32'd1150);
      send_sampled_tick(1'b0, 32'd1250);
      send_sampled_tick(1'b1, 32'd1300);
      send_sampled_tick(1'b0, 32'd1400);     // third click
      send_sampled_tick(1'b1, 32'd2000);
      send_sampled_tick(1'b1, 32'd4001);     // long press
      send_sampled_tick(1'b1, 32'd5000);
      send_sampled_tick(1'b0, 32'd5100);     // release before the pushed start
      send_sampled_tick(1'b1, 32'hffff_f000);
      send_sampled_tick(1'b1, 32'hffff_f7d1); // holdoff wraps past 2^32
      send_sampled_tick(1'b0, 32'h0000_0100);
      send_sampled_tick(1'b1, 32'd10000);
      send_sampled_tick(1'b0, 32'd10020);    // at click min
      send_sampled_tick(1'b1, 32'd10100);
      send_sampled_tick(1'b0, 32'd10121);
      send_sampled_tick(1'b1, 32'd12000);
      send_sampled_tick(1'b0, 32'd12500);    // at click max
      drain;

      // directed battery samples, evaluated on every tick from zero mV empty
      s = defaults;
      s.battery_period_ticks = 16'd1;
      s.battery_empty_mv = 14'd0;
      apply_settings(s);
      send_tick(1'b0, 32'd20000, 12'hfff, 1'b1);
      send_tick(1'b0, 32'd20050, 12'd0, 1'b1);
      send_tick(1'b0, 32'd20100, 12'd1, 1'b1);
      send_tick(1'b0, 32'd20150, 12'd300, 1'b0);
      send_tick(1'b0, 32'd20200, 12'd251, 1'b1);
      drain;

      for (p = 0; p < 7; p++) begin
         case (p)
            0: s = '{16'd1, 16'd0, 16'hffff, 16'd0, 16'hffff, 16'hffff, 16'd1, 14'd0};
            1: s = '{16'hffff, 16'hffff, 16'd1, 16'hffff, 16'd1, 16'd1, 16'hffff, 14'h3fff};
            2: s = defaults;
            default: begin
               s.long_press_ms = 16'($urandom_range(50, 600));
               s.power_off_holdoff_ms = 16'($urandom_range(0, 800));
               s.click_min_ms = 16'($urandom_range(0, 40));
               s.click_max_ms = s.click_min_ms + 16'($urandom_range(2, 200));
               s.click_gap_ms = 16'($urandom_range(20, 400));
               s.click_timeout_ms = 16'($urandom_range(10, 400));
               s.battery_period_ticks = 16'($urandom_range(1, 8));
               s.battery_empty_mv = ($urandom_range(0, 1) == 0) ?
                                    14'($urandom_range(2800, 3600)) :
                                    14'($urandom_range(0, 16383));
            end
         endcase
         apply_settings(s);
         wall_ms = ($urandom_range(0, 2) == 0) ? 32'hffff_ffff - $urandom_range(0, 3000)
                                               : 32'($urandom);
         goal = sent + 65;
         while (sent < goal) begin
            if ($urandom_range(0, 4) == 0) begin
               // noise: random level at a jumped, zero or nearby time
               case ($urandom_range(0, 3))
                  0: wall_ms = 32'($urandom);
                  1: wall_ms = 32'd0;
                  default: wall_ms = wall_ms + 32'($urandom_range(0, 100));
               endcase
               send_sampled_tick(1'($urandom_range(0, 1)), wall_ms);
            end else begin
               lo = s.click_min_ms;
               hi = s.click_max_ms;
               n = $urandom_range(1, 4);
               case ($urandom_range(0, 9))
                  0: hold_ms = lo;
                  1: hold_ms = lo + 1;
                  2: hold_ms = (hi > 0) ? hi - 1 : 0;
                  3: hold_ms = hi;
                  7: begin
                     hold_ms = s.long_press_ms * $urandom_range(1, 3) +
                               $urandom_range(1, s.power_off_holdoff_ms + 2);
                     n = $urandom_range(3, 8);
                  end
                  8: hold_ms = $urandom_range(0, 2 * s.long_press_ms);
                  9: hold_ms = 0;
                  default: hold_ms = (hi > lo + 1) ? $urandom_range(lo + 1, hi - 1) : lo + 1;
               endcase
               case ($urandom_range(0, 5))
                  0: rest_ms = $urandom_range(0, s.click_gap_ms / 2);
                  1: rest_ms = s.click_timeout_ms;
                  2: rest_ms = s.click_timeout_ms - 1;
                  3: rest_ms = s.click_gap_ms;
                  4: rest_ms = $urandom_range(0, 2 * s.click_gap_ms);
                  default: rest_ms = $urandom_range(0, 20);
               endcase
               press_gesture(hold_ms, rest_ms, n);
            end
         end
         drain;
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("button_gesture_and_battery_monitor_tb: done, clean");
      end else begin
         $display("button_gesture_and_battery_monitor_tb: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("button_gesture_and_battery_monitor_tb: done, errors");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/bgbm_pkg.sv
design/bgbm_gesture.sv
design/bgbm_battery.sv
design/button_gesture_and_battery_monitor.sv
design/bgbm_checker.sv
tb/bgbm_tick_result_check.sv
tb/button_gesture_and_battery_monitor_tb.sv
